### rtl/qxmm_pkg.sv
// Shared types and constants for the quad-X motor mixer with yaw desaturation.
// Holds the beat payload structs, stage-to-stage structs and the output clamp.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qxmm_pkg;

	// command beat
	typedef struct packed {
		logic signed [15:0] throttle_cmd;
		logic signed [15:0] roll_cmd;
		logic signed [15:0] pitch_cmd;
		logic signed [15:0] yaw_cmd;
	} qxmm_cmd_t;

	// result beat
	typedef struct packed {
		logic signed [15:0] motor_back_right;
		logic signed [15:0] motor_front_right;
		logic signed [15:0] motor_back_left;
		logic signed [15:0] motor_front_left;
		logic signed [15:0] throttle_out;
		logic        [14:0] overshoot_amount;
		logic signed [15:0] undershoot_amount;
	} qxmm_res_t;

	// live configuration
	typedef struct packed {
		logic signed [15:0] output_min;
		logic signed [15:0] output_max;
	} qxmm_cfg_t;

	// register indexes
	localparam logic REG_OUTPUT_MIN = 1'b0;
	localparam logic REG_OUTPUT_MAX = 1'b1;

	localparam logic signed [15:0] OUTPUT_MIN_RESET = 16'sd0;
	localparam logic signed [15:0] OUTPUT_MAX_RESET = 16'sd4096;

	// motor order in arrays: 0 back right, 1 front right, 2 back left, 3 front left

	// mixed motors plus distances to the limits
	typedef struct packed {
		logic [3:0][16:0] m;    // clamped mix with yaw added
		logic [3:0][17:0] lo;   // m - output_min
		logic [3:0][17:0] hi;   // m - output_max
		logic signed [15:0] thr;
		logic signed [15:0] yaw;
	} qxmm_mix_t;

	// corrected values before saturation
	typedef struct packed {
		logic [3:0][19:0] m;
		logic signed [19:0] thr;
		logic signed [17:0] over;
		logic signed [17:0] under;
	} qxmm_fix_t;

	// clamp test order: minimum first, then maximum
	function automatic logic signed [15:0] clamp_out(input logic signed [17:0] x,
			input logic signed [15:0] lo, input logic signed [15:0] hi);
		logic signed [17:0] lo_x;
		logic signed [17:0] hi_x;
		lo_x = {{2{lo[15]}}, lo};
		hi_x = {{2{hi[15]}}, hi};
		if (x < lo_x) begin
			clamp_out = lo;
		end else if (x > hi_x) begin
			clamp_out = hi;
		end else begin
			clamp_out = x[15:0];
		end
	endfunction

endpackage

`default_nettype wire

### rtl/qxmm_mix.sv
// Mixer front end: two pipeline stages. Stage 1 mixes throttle/roll/pitch and
// clamps, stage 2 adds yaw and measures distance to the limits. Uses qxmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qxmm_mix (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire qxmm_pkg::qxmm_cfg_t   cfg,
	input  wire logic                  up_valid,
	output logic                       up_ready,
	input  wire qxmm_pkg::qxmm_cmd_t   cmd,
	output logic                       dn_valid,
	input  wire logic                  dn_ready,
	output qxmm_pkg::qxmm_mix_t        dn_data
);
	import qxmm_pkg::*;

	logic signed [17:0] thr18, roll18, pitch18;
	logic signed [17:0] sum [4];

	logic               v_s1;
	logic signed [15:0] c_s1 [4];
	logic signed [15:0] thr_s1;
	logic signed [15:0] yaw_s1;
	logic               ready_s1;

	logic signed [16:0] yaw17;
	logic signed [16:0] m [4];
	logic signed [17:0] min18, max18;
	logic signed [17:0] lo [4];
	logic signed [17:0] hi [4];

	logic               v_s2;
	qxmm_mix_t          mix_s2;
	logic               ready_s2;

	assign ready_s2 = !v_s2 || dn_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign up_ready = ready_s1;
	assign dn_valid = v_s2;
	assign dn_data  = mix_s2;

	// stage 1: X mix and clamp
	always_comb begin
		thr18   = {{2{cmd.throttle_cmd[15]}}, cmd.throttle_cmd};
		roll18  = {{2{cmd.roll_cmd[15]}}, cmd.roll_cmd};
		pitch18 = {{2{cmd.pitch_cmd[15]}}, cmd.pitch_cmd};
		sum[0]  = thr18 - roll18 - pitch18;
		sum[1]  = thr18 - roll18 + pitch18;
		sum[2]  = thr18 + roll18 - pitch18;
		sum[3]  = thr18 + roll18 + pitch18;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			for (int k = 0; k < 4; k++) begin
				c_s1[k] <= clamp_out(sum[k], cfg.output_min, cfg.output_max);
			end
			thr_s1 <= cmd.throttle_cmd;
			yaw_s1 <= cmd.yaw_cmd;
		end
	end

	// stage 2: yaw in, distances to the limits
	always_comb begin
		yaw17 = {yaw_s1[15], yaw_s1};
		min18 = {{2{cfg.output_min[15]}}, cfg.output_min};
		max18 = {{2{cfg.output_max[15]}}, cfg.output_max};
		m[0]  = $signed({c_s1[0][15], c_s1[0]}) + yaw17;
		m[1]  = $signed({c_s1[1][15], c_s1[1]}) - yaw17;
		m[2]  = $signed({c_s1[2][15], c_s1[2]}) - yaw17;
		m[3]  = $signed({c_s1[3][15], c_s1[3]}) + yaw17;
		for (int k = 0; k < 4; k++) begin
			lo[k] = $signed({m[k][16], m[k]}) - min18;
			hi[k] = $signed({m[k][16], m[k]}) - max18;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			for (int k = 0; k < 4; k++) begin
				mix_s2.m[k]  <= m[k];
				mix_s2.lo[k] <= lo[k];
				mix_s2.hi[k] <= hi[k];
			end
			mix_s2.thr <= thr_s1;
			mix_s2.yaw <= yaw_s1;
		end
	end

endmodule

`default_nettype wire

### rtl/qxmm_desat.sv
// Yaw desaturation: stage 3 picks undershoot/overshoot by yaw sign, stage 4
// tests for yaw reversal and applies the correction. Uses qxmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qxmm_desat (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  up_valid,
	output logic                       up_ready,
	input  wire qxmm_pkg::qxmm_mix_t   up_data,
	output logic                       dn_valid,
	input  wire logic                  dn_ready,
	output qxmm_pkg::qxmm_fix_t        dn_data
);
	import qxmm_pkg::*;

	logic               yaw_pos, yaw_neg;
	logic signed [17:0] la, lb, ha, hb;
	logic signed [17:0] under, over;

	logic               v_s3;
	logic signed [16:0] m_s3 [4];
	logic signed [17:0] under_s3, over_s3;
	logic signed [15:0] thr_s3, yaw_s3;
	logic               ready_s3;

	logic signed [19:0] diff, yaw20, t_pos, t_neg, d, dsel, tsum, thr_new;
	logic               fix;
	logic signed [19:0] m_new [4];

	logic               v_s4;
	qxmm_fix_t          fix_s4;
	logic               ready_s4;

	assign ready_s4 = !v_s4 || dn_ready;
	assign ready_s3 = !v_s3 || ready_s4;
	assign up_ready = ready_s3;
	assign dn_valid = v_s4;
	assign dn_data  = fix_s4;

	// stage 3: yaw-lowered motors give undershoot, yaw-raised give overshoot
	always_comb begin
		yaw_pos = !up_data.yaw[15] && (up_data.yaw != 16'sd0);
		yaw_neg = up_data.yaw[15];
		la = $signed(yaw_pos ? up_data.lo[1] : up_data.lo[0]);
		lb = $signed(yaw_pos ? up_data.lo[2] : up_data.lo[3]);
		ha = $signed(yaw_pos ? up_data.hi[0] : up_data.hi[1]);
		hb = $signed(yaw_pos ? up_data.hi[3] : up_data.hi[2]);
		under = 18'sd0;
		over  = 18'sd0;
		if (yaw_pos || yaw_neg) begin
			if (la < under) under = la;
			if (lb < under) under = lb;
			if (ha > over)  over  = ha;
			if (hb > over)  over  = hb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_s3) begin
			v_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && up_valid) begin
			for (int k = 0; k < 4; k++) begin
				m_s3[k] <= $signed(up_data.m[k]);
			end
			under_s3 <= under;
			over_s3  <= over;
			thr_s3   <= up_data.thr;
			yaw_s3   <= up_data.yaw;
		end
	end

	// stage 4: correct only if yaw keeps its sign
	always_comb begin
		diff  = $signed({{2{under_s3[17]}}, under_s3}) - $signed({{2{over_s3[17]}}, over_s3});
		yaw20 = {{4{yaw_s3[15]}}, yaw_s3};
		t_pos = yaw20 + diff;
		t_neg = yaw20 - diff;
		fix   = (yaw20 > 20'sd0 && t_pos > 20'sd0) || (yaw20 < 20'sd0 && t_neg < 20'sd0);
		d     = (yaw20 > 20'sd0) ? diff : -diff;
		dsel  = fix ? d : 20'sd0;
		tsum  = $signed({{2{under_s3[17]}}, under_s3}) + $signed({{2{over_s3[17]}}, over_s3});
		thr_new = $signed({{4{thr_s3[15]}}, thr_s3}) - (fix ? tsum : 20'sd0);
		m_new[0] = $signed({{3{m_s3[0][16]}}, m_s3[0]}) + dsel;
		m_new[1] = $signed({{3{m_s3[1][16]}}, m_s3[1]}) - dsel;
		m_new[2] = $signed({{3{m_s3[2][16]}}, m_s3[2]}) - dsel;
		m_new[3] = $signed({{3{m_s3[3][16]}}, m_s3[3]}) + dsel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ready_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && v_s3) begin
			for (int k = 0; k < 4; k++) begin
				fix_s4.m[k] <= m_new[k];
			end
			fix_s4.thr   <= thr_new;
			fix_s4.over  <= over_s3;
			fix_s4.under <= under_s3;
		end
	end

	a_amount_signs: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (under_s3 <= 18'sd0) && (over_s3 >= 18'sd0))
		else $error("desat: undershoot/overshoot sign wrong");

	a_zero_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && yaw_s3 == 16'sd0) |-> (under_s3 == 18'sd0) && (over_s3 == 18'sd0))
		else $error("desat: amounts measured with zero yaw");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !dn_ready) |=> v_s4 && $stable(fix_s4))
		else $error("desat: stage 4 beat changed while held");

endmodule

`default_nettype wire

### rtl/qxmm_sat.sv
// Output stage: saturates the corrected values to the signed VALUE_BITS range
// and registers the result beat. Uses qxmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qxmm_sat #(
	parameter int VALUE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  up_valid,
	output logic                       up_ready,
	input  wire qxmm_pkg::qxmm_fix_t   up_data,
	output logic                       dn_valid,
	input  wire logic                  dn_ready,
	output qxmm_pkg::qxmm_res_t        dn_data
);
	import qxmm_pkg::*;

	localparam logic signed [32:0] SAT_HI = (33'sd1 <<< (VALUE_BITS - 1)) - 33'sd1;
	localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

	function automatic logic [15:0] sat_value(input logic signed [19:0] x);
		logic signed [32:0] xx;
		logic signed [32:0] r;
		xx = {{13{x[19]}}, x};
		if (xx > SAT_HI) begin
			r = SAT_HI;
		end else if (xx < SAT_LO) begin
			r = SAT_LO;
		end else begin
			r = xx;
		end
		sat_value = r[15:0];
	endfunction

	logic               v_s5;
	qxmm_res_t          res_s5;
	logic [15:0]        over_sat;

	assign up_ready = !v_s5 || dn_ready;
	assign dn_valid = v_s5;
	assign dn_data  = res_s5;
	assign over_sat = sat_value({{2{up_data.over[17]}}, up_data.over});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (up_ready) begin
			v_s5 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			res_s5.motor_back_right  <= sat_value(up_data.m[0]);
			res_s5.motor_front_right <= sat_value(up_data.m[1]);
			res_s5.motor_back_left   <= sat_value(up_data.m[2]);
			res_s5.motor_front_left  <= sat_value(up_data.m[3]);
			res_s5.throttle_out      <= sat_value(up_data.thr);
			res_s5.overshoot_amount  <= over_sat[14:0];
			res_s5.undershoot_amount <= sat_value({{2{up_data.under[17]}}, up_data.under});
		end
	end

endmodule

`default_nettype wire

### rtl/quad_x_motor_mixer_yaw_desat.sv
// Top level of the quad-X motor mixer with yaw desaturation: config registers
// and the five-stage pipeline. Uses qxmm_pkg, qxmm_mix, qxmm_desat, qxmm_sat.
//
//   port group     | dir | handshake              | beat
//   cmd            | in  | cmd_valid / cmd_stall  | qxmm_cmd_t (throttle, roll, pitch, yaw)
//   mix            | out | mix_valid / mix_stall  | qxmm_res_t (4 motors, throttle, amounts)
//   cfg            | in  | cfg_we                 | cfg_index, cfg_wdata
//
// One beat per cycle sustained while mix is not stalled; beats pass the s1..s5 registers.
// Each stage holds its own valid bit, so bubbles close up while mix is stalled
// and cmd_stall rises only when all five stages are full.
// Reset clears the stage valid bits and loads output_min = 0, output_max = 1.0.
// Config registers are read live by stages 1 and 2.
`timescale 1ns / 1ps
`default_nettype none

module quad_x_motor_mixer_yaw_desat #(
	parameter int VALUE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_stall,
	input  wire qxmm_pkg::qxmm_cmd_t   cmd,
	output logic                       mix_valid,
	input  wire logic                  mix_stall,
	output qxmm_pkg::qxmm_res_t        mix,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [15:0]           cfg_wdata
);
	import qxmm_pkg::*;

	qxmm_cfg_t  cfg_q;

	logic       mix_ready;
	logic       v_mix, r_mix;
	qxmm_mix_t  d_mix;
	logic       v_fix, r_fix;
	qxmm_fix_t  d_fix;
	logic       r_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_min <= OUTPUT_MIN_RESET;
			cfg_q.output_max <= OUTPUT_MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OUTPUT_MIN: cfg_q.output_min <= cfg_wdata;
				REG_OUTPUT_MAX: cfg_q.output_max <= cfg_wdata;
				default: ;
			endcase
		end
	end

	qxmm_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (cmd_valid),
		.up_ready (r_mix),
		.cmd      (cmd),
		.dn_valid (v_mix),
		.dn_ready (r_fix),
		.dn_data  (d_mix)
	);

	qxmm_desat u_desat (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_mix),
		.up_ready (r_fix),
		.up_data  (d_mix),
		.dn_valid (v_fix),
		.dn_ready (r_sat),
		.dn_data  (d_fix)
	);

	qxmm_sat #(
		.VALUE_BITS (VALUE_BITS)
	) u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (v_fix),
		.up_ready (r_sat),
		.up_data  (d_fix),
		.dn_valid (mix_valid),
		.dn_ready (mix_ready),
		.dn_data  (mix)
	);

	assign mix_ready = !mix_stall;
	assign cmd_stall = !r_mix;

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (mix_valid && mix_stall && v_fix && v_mix))
		else $error("top: input stalled while the pipeline had room");

endmodule

`default_nettype wire
